@@ sv/tsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the Taylor sine/cosine block
// Field widths, fixed-point constants, register indexes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int ANGLE_W    = 32;
    localparam int RES_W      = 32;
    localparam int WORD_W     = 36;
    localparam int MAG_W      = 35;
    localparam int RECIP_W    = 40;
    localparam int COUNT_W    = 4;
    localparam int THRESH_W   = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam int Q_FRAC     = 30;
    localparam int RECIP_FRAC = 40;

    localparam logic signed [WORD_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [WORD_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [WORD_W-1:0] ONE_Q30    = 36'sd1073741824;

    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 1'd1;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd14;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd1;

    typedef enum logic [1:0] {
        OP_SQUARE,
        OP_FACTOR,
        OP_TERM
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    reduce;
        logic    mul_go;
        mul_op_t mul_op;
        logic    take_x2;
        logic    init_sin;
        logic    take_f;
        logic    take_term;
        logic    init_cos;
        logic    load_out;
    } tsc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic below_thresh;
    } tsc_sts_t;

endpackage

`default_nettype wire

@@ sv/tsc_intf.sv @@
// ----------------------------------------------------------------------------
// tsc_intf: channel interfaces of the Taylor sine/cosine block
// Angle input channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tsc_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface tsc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tsc_pkg::RES_W-1:0] sine;
    logic signed [tsc_pkg::RES_W-1:0] cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

interface tsc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tsc_pkg::CFG_IDX_W-1:0]     index;
    logic [tsc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/tsc_mul.sv @@
// ----------------------------------------------------------------------------
// tsc_mul: shared rounding multiplier
// Forms round(a * b / 2^s) with s of 30 or 40 from two 35x20-bit partial
// products, accumulated and rounded; a one-cycle done pulse flags the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tsc_pkg::MAG_W-1:0]   a,
    input  wire logic [tsc_pkg::RECIP_W-1:0] b,
    input  wire logic                        s40,
    output logic                             done,
    output logic [tsc_pkg::MAG_W-1:0]        res
);
    import tsc_pkg::*;

    localparam int LOW_W  = RECIP_W / 2;
    localparam int HIGH_W = RECIP_W - LOW_W;
    localparam int PP_W   = MAG_W + HIGH_W;
    localparam int PROD_W = MAG_W + RECIP_W;

    localparam logic [PROD_W:0] HALF_HI = {{PROD_W{1'b0}}, 1'b1} << (RECIP_FRAC - 1);
    localparam logic [PROD_W:0] HALF_LO = {{PROD_W{1'b0}}, 1'b1} << (Q_FRAC - 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_HIGH,
        M_ACC,
        M_ROUND
    } mul_state_t;

    mul_state_t          state_reg;
    logic [MAG_W-1:0]    a_reg;
    logic [HIGH_W-1:0]   bh_reg;
    logic                s40_reg;
    logic [PP_W-1:0]     pp_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [MAG_W-1:0]    res_reg;
    logic                done_reg;
    logic [PROD_W:0]     round_sum;

    always_comb
    begin
        round_sum = {1'b0, acc_reg} + (s40_reg ? HALF_HI : HALF_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            a_reg     <= '0;
            bh_reg    <= '0;
            s40_reg   <= 1'b0;
            pp_reg    <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a;
                        bh_reg    <= b[RECIP_W-1:LOW_W];
                        s40_reg   <= s40;
                        pp_reg    <= PP_W'(a * b[LOW_W-1:0]);
                        state_reg <= M_HIGH;
                    end
                end
                M_HIGH:
                begin
                    acc_reg   <= {{(PROD_W-PP_W){1'b0}}, pp_reg};
                    pp_reg    <= PP_W'(a_reg * bh_reg);
                    state_reg <= M_ACC;
                end
                M_ACC:
                begin
                    acc_reg   <= acc_reg + {pp_reg, {LOW_W{1'b0}}};
                    state_reg <= M_ROUND;
                end
                M_ROUND:
                begin
                    res_reg   <= s40_reg ? round_sum[RECIP_FRAC +: MAG_W]
                                         : round_sum[Q_FRAC +: MAG_W];
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

@@ sv/tsc_dpath.sv @@
// ----------------------------------------------------------------------------
// tsc_dpath: datapath of the Taylor sine/cosine block
// Angle fold, reciprocal table, shared multiplier, term and sum registers,
// saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_dpath #(
    parameter int TERM_LIMIT = 15,
    localparam int IDX_MAX   = 2 * (TERM_LIMIT - 1),
    localparam int IDX_W     = $clog2(IDX_MAX + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic signed [tsc_pkg::ANGLE_W-1:0]  angle,
    input  wire logic [tsc_pkg::THRESH_W-1:0]        threshold,
    input  wire tsc_pkg::tsc_cmd_t                   cmd,
    input  wire logic [IDX_W-1:0]                    rom_idx,
    output tsc_pkg::tsc_sts_t                        sts,
    output logic signed [tsc_pkg::RES_W-1:0]         sine,
    output logic signed [tsc_pkg::RES_W-1:0]         cosine
);
    import tsc_pkg::*;

    localparam logic signed [WORD_W-1:0] RES_MAX = WORD_W'(64'sd2147483647);
    localparam logic signed [WORD_W-1:0] RES_MIN = -WORD_W'(64'sd2147483648);

    logic [RECIP_W-1:0]        recip [0:IDX_MAX];

    logic signed [WORD_W-1:0]  x_reg;
    logic [MAG_W-1:0]          x2_reg;
    logic [MAG_W-1:0]          f_reg;
    logic signed [WORD_W-1:0]  term_reg;
    logic signed [WORD_W-1:0]  sum_reg;
    logic signed [WORD_W-1:0]  sin_keep_reg;
    logic signed [RES_W-1:0]   sine_reg;
    logic signed [RES_W-1:0]   cosine_reg;

    logic [MAG_W-1:0]          x_mag;
    logic [MAG_W-1:0]          term_mag;
    logic [MAG_W-1:0]          mul_a;
    logic [RECIP_W-1:0]        mul_b;
    logic                      mul_s40;
    logic                      mul_done;
    logic [MAG_W-1:0]          mul_res;
    logic signed [WORD_W-1:0]  term_new;

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [WORD_W-1:0] v);
        logic signed [RES_W-1:0] r;
        if (v > RES_MAX)
            r = RES_W'(RES_MAX);
        else if (v < RES_MIN)
            r = RES_W'(RES_MIN);
        else
            r = RES_W'(v);
        return r;
    endfunction

    assign recip[0] = '0;
    for (genvar g = 1; g <= IDX_MAX; g++)
    begin : g_recip
        localparam longint unsigned DIV = 64'(g * (g + 1));
        localparam longint unsigned VAL = ((64'd1 << RECIP_FRAC) + DIV / 2) / DIV;
        assign recip[g] = RECIP_W'(VAL);
    end

    always_comb
    begin
        x_mag    = x_reg[WORD_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
        term_mag = term_reg[WORD_W-1] ? MAG_W'(-term_reg) : MAG_W'(term_reg);
        mul_s40  = 1'b0;
        case (cmd.mul_op)
            OP_SQUARE:
            begin
                mul_a = x_mag;
                mul_b = RECIP_W'(x_mag);
            end
            OP_FACTOR:
            begin
                mul_a   = x2_reg;
                mul_b   = recip[rom_idx];
                mul_s40 = 1'b1;
            end
            OP_TERM:
            begin
                mul_a = term_mag;
                mul_b = RECIP_W'(f_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        term_new = term_reg[WORD_W-1] ? $signed({1'b0, mul_res})
                                      : -$signed({1'b0, mul_res});
    end

    tsc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .s40   (mul_s40),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= {{(WORD_W-ANGLE_W-3){angle[ANGLE_W-1]}}, angle, 3'b000};
        else if (cmd.reduce)
        begin
            if (x_reg > PI_Q30)
                x_reg <= x_reg - TWO_PI_Q30;
            else if (x_reg < -PI_Q30)
                x_reg <= x_reg + TWO_PI_Q30;
        end

        if (cmd.take_x2)
            x2_reg <= mul_res;
        if (cmd.take_f)
            f_reg <= mul_res;

        if (cmd.init_sin)
        begin
            term_reg <= x_reg;
            sum_reg  <= x_reg;
        end
        else if (cmd.init_cos)
        begin
            sin_keep_reg <= sum_reg;
            term_reg     <= ONE_Q30;
            sum_reg      <= ONE_Q30;
        end
        else if (cmd.take_term)
        begin
            term_reg <= term_new;
            sum_reg  <= sum_reg + term_new;
        end

        if (cmd.load_out)
        begin
            sine_reg   <= sat_res(sin_keep_reg);
            cosine_reg <= sat_res(sum_reg);
        end
    end

    assign sts.mul_done     = mul_done;
    assign sts.below_thresh = mul_res < MAG_W'(threshold);
    assign sine             = sine_reg;
    assign cosine           = cosine_reg;

endmodule

`default_nettype wire

@@ sv/tsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsc_ctrl: controller of the Taylor sine/cosine block
// Sequences fold, square and the two series over the shared multiplier,
// counts terms, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_ctrl #(
    parameter int TERM_LIMIT = 15,
    localparam int IDX_MAX   = 2 * (TERM_LIMIT - 1),
    localparam int IDX_W     = $clog2(IDX_MAX + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    input  wire logic [tsc_pkg::COUNT_W-1:0]   term_count,
    input  wire tsc_pkg::tsc_sts_t             sts,
    output tsc_pkg::tsc_cmd_t                  cmd,
    output logic [IDX_W-1:0]                   rom_idx
);
    import tsc_pkg::*;

    localparam int N_W   = $clog2(TERM_LIMIT);
    localparam int CMP_W = (N_W > COUNT_W) ? N_W : COUNT_W;
    localparam logic [CMP_W-1:0] CAP   = CMP_W'(TERM_LIMIT - 1);
    localparam logic [1:0]       REDUCE_LAST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_SQ,
        S_SQ_WAIT,
        S_F,
        S_F_WAIT,
        S_T,
        S_T_WAIT,
        S_SWITCH,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      red_cnt_reg, red_cnt_next;
    logic [N_W-1:0]  n_reg, n_next;
    logic [N_W-1:0]  lim_reg, lim_next;
    logic            sine_sel_reg, sine_sel_next;
    logic            out_valid_reg, out_valid_next;
    logic [N_W-1:0]  lim_cap;

    assign lim_cap = (CMP_W'(term_count) > CAP) ? N_W'(CAP) : N_W'(term_count);

    always_comb
    begin
        state_next     = state_reg;
        red_cnt_next   = red_cnt_reg;
        n_next         = n_reg;
        lim_next       = lim_reg;
        sine_sel_next  = sine_sel_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    lim_next     = lim_cap;
                    red_cnt_next = '0;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce   = 1'b1;
                red_cnt_next = red_cnt_reg + 2'd1;
                if (red_cnt_reg == REDUCE_LAST)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = OP_SQUARE;
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.take_x2   = 1'b1;
                    cmd.init_sin  = 1'b1;
                    n_next        = N_W'(1);
                    sine_sel_next = 1'b1;
                    state_next    = (lim_reg == '0) ? S_SWITCH : S_F;
                end
            end
            S_F:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = OP_FACTOR;
                state_next = S_F_WAIT;
            end
            S_F_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.take_f = 1'b1;
                    state_next = S_T;
                end
            end
            S_T:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = OP_TERM;
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.take_term = 1'b1;
                    if (sts.below_thresh || n_reg == lim_reg)
                        state_next = sine_sel_reg ? S_SWITCH : S_DONE;
                    else
                    begin
                        n_next     = n_reg + N_W'(1);
                        state_next = S_F;
                    end
                end
            end
            S_SWITCH:
            begin
                cmd.init_cos  = 1'b1;
                sine_sel_next = 1'b0;
                n_next        = N_W'(1);
                state_next    = (lim_reg == '0) ? S_DONE : S_F;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            red_cnt_reg   <= '0;
            n_reg         <= '0;
            lim_reg       <= '0;
            sine_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            red_cnt_reg   <= red_cnt_next;
            n_reg         <= n_next;
            lim_reg       <= lim_next;
            sine_sel_reg  <= sine_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rom_idx   = IDX_W'({n_reg, 1'b0}) - IDX_W'(!sine_sel_reg);

`ifndef SYNTHESIS
    a_load_starts_fold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_REDUCE)
        else $error("accepted angle did not start the fold");

    a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_F |-> (n_reg != '0 && n_reg <= lim_reg))
        else $error("term index outside the counted range");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> (state_reg == S_SQ_WAIT || state_reg == S_F_WAIT ||
                          state_reg == S_T_WAIT))
        else $error("multiplier finished outside a wait state");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=>
        (state_reg == S_DONE && out_valid_reg))
        else $error("result overwritten while the output is full");
`endif

endmodule

`default_nettype wire

@@ sv/taylor_sine_cosine.sv @@
// ----------------------------------------------------------------------------
// taylor_sine_cosine: sine and cosine of one angle by Taylor series
// Takes an angle in radians (signed Q4.27), folds it into [-pi, pi] and
// returns sine and cosine in signed Q1.30, saturated. Each series adds up to
// term_count terms (capped at TERM_LIMIT - 1) and stops early after a term
// whose magnitude in result LSBs is below stop_threshold. One item is worked
// at a time on a single shared rounding multiplier (two 35x20-bit passes a
// product, two products a term); the next angle is taken only after both
// series are done and the result has been moved to the output register.
// A finished result waits in the output register while the next angle is
// accepted. Configuration is written through the cfg channel (index 0:
// term_count, index 1: stop_threshold); the user must write it only while
// the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine #(
    parameter int TERM_LIMIT = 15
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsc_in_if.sink     angle_ch,
    tsc_out_if.source  result_ch,
    tsc_cfg_if.sink    cfg
);
    import tsc_pkg::*;

    localparam int IDX_MAX = 2 * (TERM_LIMIT - 1);
    localparam int IDX_W   = $clog2(IDX_MAX + 1);

    logic [COUNT_W-1:0]  term_count_reg;
    logic [THRESH_W-1:0] stop_threshold_reg;
    tsc_cmd_t            cmd;
    tsc_sts_t            sts;
    logic [IDX_W-1:0]    rom_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg     <= COUNT_RESET;
            stop_threshold_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TERM_COUNT:     term_count_reg     <= cfg.data[COUNT_W-1:0];
                REG_STOP_THRESHOLD: stop_threshold_reg <= cfg.data[THRESH_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    tsc_ctrl #(
        .TERM_LIMIT (TERM_LIMIT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (angle_ch.valid),
        .in_ready   (angle_ch.ready),
        .out_valid  (result_ch.valid),
        .out_ready  (result_ch.ready),
        .term_count (term_count_reg),
        .sts        (sts),
        .cmd        (cmd),
        .rom_idx    (rom_idx)
    );

    tsc_dpath #(
        .TERM_LIMIT (TERM_LIMIT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .angle     (angle_ch.angle),
        .threshold (stop_threshold_reg),
        .cmd       (cmd),
        .rom_idx   (rom_idx),
        .sts       (sts),
        .sine      (result_ch.sine),
        .cosine    (result_ch.cosine)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Taylor sine/cosine block
// Drives angles on the input channel and rewrites term_count and
// stop_threshold between phases while the block is idle. A fixed-point
// predictor folds each angle and sums both series, and a monitor compares
// every result field with the oldest prediction. Random gaps on the input,
// random stalls on the result channel, and phases with no gaps at all.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import tsc_pkg::*;

    localparam int          TERM_LIMIT    = 15;
    localparam int          RANDOM_PHASES = 9;
    localparam int          PHASE_ITEMS   = 210;
    localparam int          DRAIN_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    localparam logic signed [ANGLE_W-1:0] PI_ANGLE      = 32'sd421657428;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_ANGLE = 32'sd210828714;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN     = 32'sh80000000;

    typedef struct packed {
        logic signed [RES_W-1:0] sine;
        logic signed [RES_W-1:0] cosine;
    } sincos_t;

    logic clk = 1'b0;
    logic rst_n;

    tsc_in_if  angle_ch ();
    tsc_out_if result_ch ();
    tsc_cfg_if cfg_ch ();

    taylor_sine_cosine #(
        .TERM_LIMIT(TERM_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle_ch (angle_ch),
        .result_ch(result_ch),
        .cfg      (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sincos_t              sincos_q[$];
    logic [COUNT_W-1:0]   cfg_terms  = COUNT_RESET;
    logic [THRESH_W-1:0]  cfg_thresh = THRESH_RESET;
    bit                   quiet      = 1'b0;
    int                   errors     = 0;
    int                   n_sent     = 0;
    int                   n_checked  = 0;
    int                   n_settings = 1;

    function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = (p + (128'd1 << (s - 1))) >> s;
        return p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] recip_q40(input logic [63:0] d);
        return ((64'd1 << RECIP_FRAC) + d / 2) / d;
    endfunction

    function automatic logic signed [RES_W-1:0] saturate(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[RES_W-1:0];
    endfunction

    function automatic logic signed [63:0] sum_series(input logic signed [63:0] start,
                                                      input logic [63:0] x2,
                                                      input bit is_sine,
                                                      input int terms,
                                                      input logic [THRESH_W-1:0] thresh);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        logic [63:0]        d;
        logic [63:0]        f;
        logic [63:0]        mag;
        sum  = start;
        term = start;
        for (int n = 1; n <= terms; n++)
        begin
            d    = is_sine ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            f    = round_mul(x2, recip_q40(d), RECIP_FRAC);
            mag  = round_mul(magnitude(term), f, Q_FRAC);
            term = (term < 0) ? $signed(mag) : -$signed(mag);
            sum  = sum + term;
            if (magnitude(term) < {44'd0, thresh})
                break;
        end
        return sum;
    endfunction

    function automatic sincos_t predict_sincos(input logic signed [ANGLE_W-1:0] angle,
                                               input logic [COUNT_W-1:0] terms_cfg,
                                               input logic [THRESH_W-1:0] thresh);
        logic signed [63:0] pi;
        logic signed [63:0] two_pi;
        logic signed [63:0] one;
        logic signed [63:0] x;
        logic [63:0]        x2;
        int                 terms;
        sincos_t            r;
        pi     = PI_Q30;
        two_pi = TWO_PI_Q30;
        one    = ONE_Q30;
        x      = angle;
        x      = x * 64'sd8;
        for (int i = 0; i < 3; i++)
        begin
            if (x > pi)
                x = x - two_pi;
            else if (x < -pi)
                x = x + two_pi;
        end
        terms    = (terms_cfg > TERM_LIMIT - 1) ? TERM_LIMIT - 1 : int'(terms_cfg);
        x2       = round_mul(magnitude(x), magnitude(x), Q_FRAC);
        r.sine   = saturate(sum_series(x, x2, 1'b1, terms, thresh));
        r.cosine = saturate(sum_series(one, x2, 1'b0, terms, thresh));
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        logic signed [ANGLE_W-1:0] base;
        logic signed [ANGLE_W-1:0] offset;
        int                        sel;
        int                        k;
        sel    = $urandom_range(0, 19);
        base   = $urandom;
        offset = $signed($urandom) >>> $urandom_range(8, 31);
        if (sel < 8)
            return base;
        if (sel < 12)
            return base >>> $urandom_range(4, 31);
        if (sel < 17)
        begin
            k    = 2 * int'($urandom_range(0, 2)) + 1;
            base = PI_ANGLE * k + $signed(32'($urandom_range(0, 128))) - 32'sd64;
            return $urandom_range(0, 1) ? base : -base;
        end
        if (sel < 19)
        begin
            k    = $urandom_range(0, 10);
            base = HALF_PI_ANGLE * k + offset;
            return $urandom_range(0, 1) ? base : -base;
        end
        base = $urandom_range(0, 255);
        return $urandom_range(0, 1) ? ANGLE_MAX - base : ANGLE_MIN + base;
    endfunction

    function automatic logic [THRESH_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 20'd1;
            2: return 20'hFFFFF;
            3: return 20'($urandom_range(2, 4096));
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            angle_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        angle_ch.valid <= 1'b1;
        angle_ch.angle <= angle;
        @(posedge clk);
        while (!angle_ch.ready)
            @(posedge clk);
        sincos_q.push_back(predict_sincos(angle, cfg_terms, cfg_thresh));
        n_sent++;
    endtask

    task automatic wait_idle();
        angle_ch.valid <= 1'b0;
        while (sincos_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] count_data,
                              input logic [CFG_DATA_W-1:0] thresh_data);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_TERM_COUNT;
        cfg_ch.data  <= count_data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_terms    = count_data[COUNT_W-1:0];
        cfg_ch.index <= REG_STOP_THRESHOLD;
        cfg_ch.data  <= thresh_data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_thresh   = thresh_data[THRESH_W-1:0];
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic flag(input string what, input logic signed [RES_W-1:0] want,
                        input logic signed [RES_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("ERROR %s: expected %0d (%h), got %0d (%h)", what, want, want, got, got);
    endtask

    task automatic test_default_config();
        logic signed [ANGLE_W-1:0] angles [12];
        angles = '{32'sd0, 32'sd1, -32'sd1, ANGLE_MAX, ANGLE_MIN, PI_ANGLE, PI_ANGLE + 32'sd1,
                   -PI_ANGLE, -PI_ANGLE - 32'sd1, HALF_PI_ANGLE, -HALF_PI_ANGLE,
                   PI_ANGLE * 3 + 32'sd1};
        foreach (angles[i])
            send_angle(angles[i]);
    endtask

    task automatic test_term_count_limits();
        set_config(20'hFFFF0, 20'd1);
        send_angle(ANGLE_MAX);
        send_angle(PI_ANGLE);
        send_angle(32'sd12345);
        set_config(20'hFFFFF, 20'd1);
        send_angle(ANGLE_MAX);
        send_angle(-PI_ANGLE);
        set_config(20'h00001, 20'd1);
        send_angle(PI_ANGLE);
        send_angle(-PI_ANGLE);
    endtask

    task automatic test_threshold_limits();
        set_config(20'd14, 20'd0);
        send_angle(HALF_PI_ANGLE);
        send_angle(ANGLE_MAX);
        set_config(20'd14, 20'hFFFFF);
        send_angle(PI_ANGLE);
        send_angle(32'sd1);
    endtask

    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] count_data;
        logic [CFG_DATA_W-1:0] thresh_data;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            count_data = {16'($urandom), 4'($urandom_range(0, 15))};
            thresh_data = pick_threshold();
            case (p)
                0: begin count_data[3:0] = 4'd14; thresh_data = 20'd1;      end
                1: begin count_data[3:0] = 4'd15; thresh_data = 20'd0;      end
                2: begin count_data[3:0] = 4'd1;  thresh_data = 20'hFFFFF;  end
                3: count_data[3:0] = 4'd0;
                default: ;
            endcase
            set_config(count_data, thresh_data);
            quiet = (p % 3 == 1);
            repeat (PHASE_ITEMS)
                send_angle(pick_angle());
        end
        quiet = 1'b0;
    endtask

    initial
    begin : result_monitor
        sincos_t want;
        int      stall;
        stall           = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (sincos_q.size() == 0)
                    flag("result with nothing pending, sine", '0, result_ch.sine);
                else
                begin
                    want = sincos_q.pop_front();
                    n_checked++;
                    if (result_ch.sine !== want.sine)
                        flag("sine", want.sine, result_ch.sine);
                    if (result_ch.cosine !== want.cosine)
                        flag("cosine", want.cosine, result_ch.cosine);
                end
            end
            if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results pending", cycles, sincos_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        angle_ch.valid = 1'b0;
        angle_ch.angle = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_term_count_limits();
        test_threshold_limits();
        test_random_settings();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d angles across %0d register settings, checked %0d results",
                 n_sent, n_settings, n_checked);
        $display("Covered folds past +-pi, term counts 0 to 15, thresholds 0 to max, stalls");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ taylor_sine_cosine.f @@
sv/tsc_pkg.sv
sv/tsc_intf.sv
sv/tsc_mul.sv
sv/tsc_dpath.sv
sv/tsc_ctrl.sv
sv/taylor_sine_cosine.sv
dv/testbench.sv
